// ----- hdl/height_map_bilinear_sampler_top_defines.svh -----
// Assertion macros for the height map sampler.
// Used by the top level; no other dependencies.
`ifndef HEIGHT_MAP_BILINEAR_SAMPLER_TOP_DEFINES_SVH
`define HEIGHT_MAP_BILINEAR_SAMPLER_TOP_DEFINES_SVH

// Same-cycle implication under reset.
`define HMBS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under reset.
`define HMBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/hmbs_pkg.sv -----
// Shared types and constants for the height map bilinear sampler.
// No dependencies.
`default_nettype none

package hmbs_pkg;

  localparam int GRID_STRIDE = 128;
  localparam int GRID_ROWS   = 128;
  localparam int GRID_DEPTH  = GRID_ROWS * GRID_STRIDE;
  localparam int ADDR_W      = $clog2(GRID_DEPTH);
  localparam int HEIGHT_W    = 16;

  localparam logic [2:0] REG_HALF_X = 3'd0;
  localparam logic [2:0] REG_HALF_Z = 3'd1;
  localparam logic [2:0] REG_INV_X  = 3'd2;
  localparam logic [2:0] REG_INV_Z  = 3'd3;
  localparam logic [2:0] REG_LAST_X = 3'd4;
  localparam logic [2:0] REG_LAST_Z = 3'd5;

  localparam logic [14:0] HALF_RST = 15'd0;
  localparam logic [15:0] INV_RST  = 16'd256;
  localparam logic [6:0]  LAST_RST = 7'd126;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULX,
    ST_MULZ,
    ST_LOC,
    ST_READ,
    ST_DRAIN,
    ST_DONE
  } fsm_state_e;

  typedef struct packed {
    logic [6:0] cidx;
    logic [7:0] frac;
    logic       clamp;
  } loc_t;

endpackage

`default_nettype wire

// ----- hdl/hmbs_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module hmbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/height_map_bilinear_sampler_top.sv -----
// Height map sampler: a write beat stores one Q8.8 height in the grid RAM, a sample beat
// returns the bilinear blend of the four grid points around a world position, clamping
// to the edge cell (and flagging it) outside the grid. A write beat goes from acceptance
// straight to the done state; a sample beat first makes two passes through the one
// shared position multiplier, a locate step, four corner reads issued one per cycle
// through the single read port of the grid RAM, and a multiply-accumulate drain.
// A result held in the output register does not block the next input beat.
// Heights read from grid points never written since reset are undefined.
// Depends on hmbs_pkg, hmbs_ram and height_map_bilinear_sampler_top_defines.svh.
`default_nettype none
`include "height_map_bilinear_sampler_top_defines.svh"

module height_map_bilinear_sampler_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // stream in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [6:0] grid_x, [13:7] grid_z, [29:14] height_in, [45:30] pos_x, [61:46] pos_z
  input  wire logic [63:0] s_axis_tdata,
  // [0] op
  input  wire logic        s_axis_tuser,
  // stream out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] height_out
  output logic [15:0]      m_axis_tdata,
  // [0] clamped
  output logic             m_axis_tuser,
  // config
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // ---------------- configuration ----------------
  logic [14:0] half_x_q, half_z_q;
  logic [15:0] inv_x_q, inv_z_q;
  logic [6:0]  last_x_q, last_z_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_x_q <= hmbs_pkg::HALF_RST;
      half_z_q <= hmbs_pkg::HALF_RST;
      inv_x_q  <= hmbs_pkg::INV_RST;
      inv_z_q  <= hmbs_pkg::INV_RST;
      last_x_q <= hmbs_pkg::LAST_RST;
      last_z_q <= hmbs_pkg::LAST_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        hmbs_pkg::REG_HALF_X: half_x_q <= pwdata[14:0];
        hmbs_pkg::REG_HALF_Z: half_z_q <= pwdata[14:0];
        hmbs_pkg::REG_INV_X:  inv_x_q  <= pwdata[15:0];
        hmbs_pkg::REG_INV_Z:  inv_z_q  <= pwdata[15:0];
        hmbs_pkg::REG_LAST_X: last_x_q <= pwdata[6:0];
        hmbs_pkg::REG_LAST_Z: last_z_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      hmbs_pkg::REG_HALF_X: prdata = {17'd0, half_x_q};
      hmbs_pkg::REG_HALF_Z: prdata = {17'd0, half_z_q};
      hmbs_pkg::REG_INV_X:  prdata = {16'd0, inv_x_q};
      hmbs_pkg::REG_INV_Z:  prdata = {16'd0, inv_z_q};
      hmbs_pkg::REG_LAST_X: prdata = {25'd0, last_x_q};
      hmbs_pkg::REG_LAST_Z: prdata = {25'd0, last_z_q};
      default:              prdata = 32'd0;
    endcase
  end

  // ---------------- input fields ----------------
  logic [6:0]  in_gx, in_gz;
  logic [15:0] in_height, in_pos_x, in_pos_z;
  logic        in_acc;

  assign in_gx     = s_axis_tdata[6:0];
  assign in_gz     = s_axis_tdata[13:7];
  assign in_height = s_axis_tdata[29:14];
  assign in_pos_x  = s_axis_tdata[45:30];
  assign in_pos_z  = s_axis_tdata[61:46];
  assign in_acc    = s_axis_tvalid & s_axis_tready;

  // ---------------- state ----------------
  hmbs_pkg::fsm_state_e st_q, st_d;
  logic [1:0]  corner_q;
  logic        va_q, vb_q;
  logic        out_free;

  logic        op_q;
  logic [15:0] pos_x_q, pos_z_q;
  logic signed [32:0] px_q, pz_q;
  logic [6:0]  cx_q, cz_q;
  logic [7:0]  fx_q, fz_q;
  logic        clamp_q;
  logic [16:0] w_a_q;
  logic        oob_a_q;
  logic signed [33:0] prod_q, acc_q;

  // ---------------- RAM ----------------
  logic                        ram_we, ram_re;
  logic [hmbs_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [15:0]                 ram_rdata;
  logic [7:0]                  row, col;
  logic                        oob;

  assign ram_we = in_acc & (s_axis_tuser == hmbs_pkg::OP_WRITE) &
                  (32'(in_gx) < hmbs_pkg::GRID_ROWS) & (32'(in_gz) < hmbs_pkg::GRID_STRIDE);
  assign ram_waddr = hmbs_pkg::ADDR_W'(32'(in_gx) * hmbs_pkg::GRID_STRIDE + 32'(in_gz));

  assign row = {1'b0, cx_q} + {7'd0, corner_q[0]};
  assign col = {1'b0, cz_q} + {7'd0, corner_q[1]};
  assign oob = (32'(row) >= hmbs_pkg::GRID_ROWS) | (32'(col) >= hmbs_pkg::GRID_STRIDE);
  assign ram_raddr = hmbs_pkg::ADDR_W'(32'(row) * hmbs_pkg::GRID_STRIDE + 32'(col));

  hmbs_ram #(
    .WIDTH (hmbs_pkg::HEIGHT_W),
    .DEPTH (hmbs_pkg::GRID_DEPTH)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_height),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------- shared position multiplier ----------------
  logic signed [16:0] mul_u, mul_inv;
  logic signed [33:0] mul_p;

  always_comb begin
    if (st_q == hmbs_pkg::ST_MULX) begin
      mul_u   = $signed({pos_x_q[15], pos_x_q}) + $signed({2'b00, half_x_q});
      mul_inv = $signed({1'b0, inv_x_q});
    end else begin
      mul_u   = $signed({pos_z_q[15], pos_z_q}) + $signed({2'b00, half_z_q});
      mul_inv = $signed({1'b0, inv_z_q});
    end
    mul_p = mul_u * mul_inv;
  end

  // ---------------- locate ----------------
  function automatic hmbs_pkg::loc_t locate(logic signed [32:0] p, logic [6:0] last);
    hmbs_pkg::loc_t r;
    if (p[32]) begin
      r.cidx  = 7'd0;
      r.frac  = 8'd0;
      r.clamp = 1'b1;
    end else if (p[31:16] > {9'd0, last}) begin
      r.cidx  = last;
      r.frac  = 8'hFF;
      r.clamp = 1'b1;
    end else begin
      r.cidx  = p[22:16];
      r.frac  = p[15:8];
      r.clamp = 1'b0;
    end
    return r;
  endfunction

  hmbs_pkg::loc_t loc_x, loc_z;
  assign loc_x = locate(px_q, last_x_q);
  assign loc_z = locate(pz_q, last_z_q);

  // corner weight
  logic [8:0]  wx, wz;
  logic [16:0] wgt;
  assign wx  = corner_q[0] ? {1'b0, fx_q} : 9'd256 - {1'b0, fx_q};
  assign wz  = corner_q[1] ? {1'b0, fz_q} : 9'd256 - {1'b0, fz_q};
  assign wgt = {8'd0, wx} * {8'd0, wz};

  // ---------------- sequencer ----------------
  assign out_free = ~m_axis_tvalid | m_axis_tready;

  always_comb begin
    st_d          = st_q;
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    unique case (st_q)
      hmbs_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          st_d = (s_axis_tuser == hmbs_pkg::OP_SAMPLE) ? hmbs_pkg::ST_MULX : hmbs_pkg::ST_DONE;
        end
      end
      hmbs_pkg::ST_MULX: st_d = hmbs_pkg::ST_MULZ;
      hmbs_pkg::ST_MULZ: st_d = hmbs_pkg::ST_LOC;
      hmbs_pkg::ST_LOC:  st_d = hmbs_pkg::ST_READ;
      hmbs_pkg::ST_READ: begin
        ram_re = 1'b1;
        if (corner_q == 2'd3) begin
          st_d = hmbs_pkg::ST_DRAIN;
        end
      end
      hmbs_pkg::ST_DRAIN: begin
        if (!va_q && !vb_q) begin
          st_d = hmbs_pkg::ST_DONE;
        end
      end
      hmbs_pkg::ST_DONE: begin
        if (out_free) begin
          st_d = hmbs_pkg::ST_IDLE;
        end
      end
      default: st_d = hmbs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= hmbs_pkg::ST_IDLE;
      corner_q      <= 2'd0;
      va_q          <= 1'b0;
      vb_q          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      st_q <= st_d;
      va_q <= (st_q == hmbs_pkg::ST_READ);
      vb_q <= va_q;
      if (st_q == hmbs_pkg::ST_READ) begin
        corner_q <= corner_q + 2'd1;
      end else begin
        corner_q <= 2'd0;
      end
      if (st_q == hmbs_pkg::ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= s_axis_tuser;
      pos_x_q <= in_pos_x;
      pos_z_q <= in_pos_z;
    end
    if (st_q == hmbs_pkg::ST_MULX) begin
      px_q <= mul_p[32:0];
    end
    if (st_q == hmbs_pkg::ST_MULZ) begin
      pz_q <= mul_p[32:0];
    end
    if (st_q == hmbs_pkg::ST_LOC) begin
      cx_q    <= loc_x.cidx;
      fx_q    <= loc_x.frac;
      cz_q    <= loc_z.cidx;
      fz_q    <= loc_z.frac;
      clamp_q <= loc_x.clamp | loc_z.clamp;
      acc_q   <= '0;
    end
    if (st_q == hmbs_pkg::ST_READ) begin
      w_a_q   <= wgt;
      oob_a_q <= oob;
    end
    if (va_q) begin
      prod_q <= oob_a_q ? 34'sd0 : $signed(ram_rdata) * $signed({1'b0, w_a_q});
    end
    if (vb_q) begin
      acc_q <= acc_q + prod_q;
    end
    if (st_q == hmbs_pkg::ST_DONE && out_free) begin
      m_axis_tdata <= (op_q == hmbs_pkg::OP_SAMPLE) ? acc_q[31:16] : 16'd0;
      m_axis_tuser <= (op_q == hmbs_pkg::OP_SAMPLE) & clamp_q;
    end
  end

  // ---------------- assertions ----------------
  `HMBS_ASSERT_NOW(a_idle_no_mac, clk_i, rst_ni, s_axis_tready, !va_q && !vb_q,
    "input taken while accumulate pipeline busy")
  `HMBS_ASSERT_NEXT(a_sample_starts, clk_i, rst_ni,
    in_acc && s_axis_tuser == hmbs_pkg::OP_SAMPLE, st_q == hmbs_pkg::ST_MULX,
    "sample beat did not start the multiplier")
  `HMBS_ASSERT_NEXT(a_write_done, clk_i, rst_ni,
    in_acc && s_axis_tuser == hmbs_pkg::OP_WRITE, st_q == hmbs_pkg::ST_DONE,
    "write beat did not go to completion")
  `HMBS_ASSERT_NEXT(a_last_corner, clk_i, rst_ni,
    st_q == hmbs_pkg::ST_READ && corner_q == 2'd3, st_q == hmbs_pkg::ST_DRAIN && va_q,
    "fourth corner read not followed by drain")
  `HMBS_ASSERT_NEXT(a_result_out, clk_i, rst_ni,
    st_q == hmbs_pkg::ST_DONE && out_free, m_axis_tvalid,
    "completed item not presented")

endmodule

`default_nettype wire
